>>> rtl/pfe_pkg.sv
// ============================================================================
// pfe_pkg: shared types, constants and step function
// Sizes, request/mode/op codes and the per-entry colour step of the fade engine.
// ============================================================================
package pfe_pkg;

    // Store shape and fade timing
    localparam int ENTRIES     = 64;
    localparam int BANKS       = 2;
    localparam int FADE_FRAMES = 22;
    localparam int STEP        = 32;

    localparam int DEPTH   = BANKS * ENTRIES;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int ENT_W   = $clog2(ENTRIES);
    // wide enough for first + span and for ENTRIES - 1
    localparam int RANGE_W = 9;

    localparam logic [7:0] STEP_LVL  = 8'(STEP);
    localparam logic [7:0] WHITE_LVL = 8'd224;

    // Request codes
    localparam logic [2:0] REQ_WR_TGT  = 3'd0;
    localparam logic [2:0] REQ_WR_WORK = 3'd1;
    localparam logic [2:0] REQ_RD_WORK = 3'd2;
    localparam logic [2:0] REQ_START   = 3'd3;
    localparam logic [2:0] REQ_TICK    = 3'd4;

    // Fade modes
    localparam logic [2:0] MODE_NONE      = 3'd0;
    localparam logic [2:0] MODE_FADE_IN   = 3'd1;
    localparam logic [2:0] MODE_FADE_OUT  = 3'd2;
    localparam logic [2:0] MODE_FLASH_IN  = 3'd3;
    localparam logic [2:0] MODE_FLASH_OUT = 3'd4;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPAN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP  = 2'd2;

    // Datapath operations issued by the controller
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE    = 4'd0;
    localparam logic [OP_W-1:0] OP_CLEAR   = 4'd1;
    localparam logic [OP_W-1:0] OP_CAPTURE = 4'd2;
    localparam logic [OP_W-1:0] OP_HOST_WR = 4'd3;
    localparam logic [OP_W-1:0] OP_HOST_RD = 4'd4;
    localparam logic [OP_W-1:0] OP_START   = 4'd5;
    localparam logic [OP_W-1:0] OP_FILL    = 4'd6;
    localparam logic [OP_W-1:0] OP_TICK    = 4'd7;
    localparam logic [OP_W-1:0] OP_SWEEP   = 4'd8;
    localparam logic [OP_W-1:0] OP_LOAD    = 4'd9;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } rgb_t;

    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic             bank;
        logic [ENT_W-1:0] ent;
    } pfe_cmd_t;

    typedef struct packed {
        logic mode_active;
        logic fill_needed;
        logic out_free;
    } pfe_stat_t;

    // One tick of one entry. In-modes only move entries inside the range.
    function automatic rgb_t pfe_step(input logic [2:0] mode, input rgb_t w,
                                      input rgb_t t, input logic in_rng);
        rgb_t r;
        r = w;
        case (mode)
            MODE_FADE_IN:
            begin
                if (in_rng)
                begin
                    if (t.blue > w.blue)        r.blue  = w.blue + STEP_LVL;
                    else if (t.green > w.green) r.green = w.green + STEP_LVL;
                    else if (t.red > w.red)     r.red   = w.red + STEP_LVL;
                end
            end
            MODE_FLASH_IN:
            begin
                if (in_rng)
                begin
                    if (t.blue < w.blue)        r.blue  = w.blue - STEP_LVL;
                    else if (t.green < w.green) r.green = w.green - STEP_LVL;
                    else if (t.red < w.red)     r.red   = w.red - STEP_LVL;
                end
            end
            MODE_FADE_OUT:
            begin
                if (w.red != 8'd0)        r.red   = w.red - STEP_LVL;
                else if (w.green != 8'd0) r.green = w.green - STEP_LVL;
                else if (w.blue != 8'd0)  r.blue  = w.blue - STEP_LVL;
            end
            MODE_FLASH_OUT:
            begin
                if (w.red != WHITE_LVL)        r.red   = w.red + STEP_LVL;
                else if (w.green != WHITE_LVL) r.green = w.green + STEP_LVL;
                else if (w.blue != WHITE_LVL)  r.blue  = w.blue + STEP_LVL;
            end
            default:
            begin
                r = w;
            end
        endcase
        return r;
    endfunction

endpackage

>>> rtl/pfe_ram.sv
// ============================================================================
// pfe_ram: generic single-write, single-read RAM
// One write port, one read port with enable and registered read data.
// ============================================================================
module pfe_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/pfe_ctrl.sv
// ============================================================================
// pfe_ctrl: request sequencer
// State machine and entry counter; issues one datapath operation per cycle.
// ============================================================================
module pfe_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic [2:0]         req_type,
    input  pfe_pkg::pfe_stat_t stat,
    output logic               in_stall,
    output pfe_pkg::pfe_cmd_t  cmd
);
    import pfe_pkg::*;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_WRITE  = 4'd2;
    localparam logic [3:0] S_READ   = 4'd3;
    localparam logic [3:0] S_START  = 4'd4;
    localparam logic [3:0] S_FILL   = 4'd5;
    localparam logic [3:0] S_TICK   = 4'd6;
    localparam logic [3:0] S_SWEEP  = 4'd7;
    localparam logic [3:0] S_DRAIN  = 4'd8;
    localparam logic [3:0] S_RESULT = 4'd9;

    logic [3:0]       state_reg;
    logic [3:0]       state_next;
    logic [ENT_W-1:0] ent_reg;
    logic             bank_reg;
    logic             adv;
    logic             ent_last;
    logic             bank_last;
    logic             cnt_last;

    assign ent_last  = (ent_reg == ENT_W'(ENTRIES - 1));
    assign bank_last = (bank_reg == 1'(BANKS - 1));
    assign cnt_last  = ent_last && bank_last;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        cmd.bank   = bank_reg;
        cmd.ent    = ent_reg;
        adv        = 1'b0;
        in_stall   = 1'b1;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.op = OP_CLEAR;
                adv    = 1'b1;
                if (cnt_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.op = OP_CAPTURE;
                    case (req_type)
                        REQ_WR_TGT:  state_next = S_WRITE;
                        REQ_WR_WORK: state_next = S_WRITE;
                        REQ_RD_WORK: state_next = S_READ;
                        REQ_START:   state_next = S_START;
                        REQ_TICK:    state_next = S_TICK;
                        default:     state_next = S_RESULT;
                    endcase
                end
            end
            S_WRITE:
            begin
                cmd.op     = OP_HOST_WR;
                state_next = S_RESULT;
            end
            S_READ:
            begin
                cmd.op     = OP_HOST_RD;
                state_next = S_RESULT;
            end
            S_START:
            begin
                cmd.op     = OP_START;
                state_next = stat.fill_needed ? S_FILL : S_RESULT;
            end
            S_FILL:
            begin
                cmd.op = OP_FILL;
                adv    = 1'b1;
                if (ent_last)
                begin
                    state_next = S_RESULT;
                end
            end
            S_TICK:
            begin
                cmd.op     = OP_TICK;
                state_next = stat.mode_active ? S_SWEEP : S_RESULT;
            end
            S_SWEEP:
            begin
                cmd.op = OP_SWEEP;
                adv    = 1'b1;
                if (cnt_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                // last write-back lands this cycle
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            ent_reg   <= '0;
            bank_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (adv)
            begin
                if (ent_last)
                begin
                    ent_reg  <= '0;
                    // fill stays in bank one
                    bank_reg <= (bank_last || state_reg == S_FILL) ? 1'b0 : bank_reg + 1'b1;
                end
                else
                begin
                    ent_reg <= ent_reg + 1'b1;
                end
            end
        end
    end

    // counter is home again when a sweep ends
    a_sweep_wraps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SWEEP && state_next == S_DRAIN) |=> (ent_reg == '0 && !bank_reg))
        else $error("sweep counter not back at zero");

    a_fill_bank_one: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FILL) |-> !bank_reg)
        else $error("fill strayed into bank two");

    a_clear_ends_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR && cnt_last) |=> (state_reg == S_IDLE && ent_reg == '0))
        else $error("clearing pass did not end cleanly");

endmodule

>>> rtl/pfe_datapath.sv
// ============================================================================
// pfe_datapath: palette stores, fade state and result register
// Two RAMs, configuration, mode and frame counter, entry step, output stage.
// ============================================================================
module pfe_datapath (
    input  logic                             clk,
    input  logic                             rst_n,
    input  pfe_pkg::pfe_cmd_t                cmd,
    input  logic                             cfg_write,
    input  logic [pfe_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [5:0]                       cfg_data,
    input  logic [2:0]                       req_type,
    input  logic                             bank,
    input  logic [5:0]                       entry,
    input  logic [7:0]                       red_in,
    input  logic [7:0]                       green_in,
    input  logic [7:0]                       blue_in,
    input  logic [2:0]                       fade_mode,
    input  logic                             out_stall,
    output logic                             out_valid,
    output logic [7:0]                       red_out,
    output logic [7:0]                       green_out,
    output logic [7:0]                       blue_out,
    output logic                             done_res,
    output logic [4:0]                       frames_done,
    output pfe_pkg::pfe_stat_t               stat
);
    import pfe_pkg::*;

    // configuration
    logic [5:0] first_reg;
    logic [5:0] span_reg;
    logic       skip_reg;

    // fade state
    logic [2:0] mode_reg;
    logic [4:0] fc_reg;
    logic [4:0] fc_inc;
    logic       tick_done_reg;

    // captured request
    logic [2:0] rq_type_reg;
    logic       rq_bank_reg;
    logic [5:0] rq_entry_reg;
    rgb_t       rq_rgb_reg;
    logic [2:0] rq_mode_reg;
    logic [2:0] start_mode;

    // sweep write-back stage
    logic              wb_vld_reg;
    logic [ADDR_W-1:0] wb_addr_reg;
    logic              wb_elig_reg;

    // output stage
    logic       out_valid_reg;
    rgb_t       out_rgb_reg;
    logic       out_done_reg;
    logic [4:0] out_fc_reg;

    logic [RANGE_W-1:0] range_sum;
    logic [RANGE_W-1:0] range_last;
    logic               ent_in_rng;
    logic               bank_in;
    logic               host_ok;
    logic [ADDR_W-1:0]  host_addr;
    logic [ADDR_W-1:0]  sweep_addr;
    logic [7:0]         fill_lvl;

    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    rgb_t              w_wdata;
    logic              w_re;
    logic [ADDR_W-1:0] rd_addr;
    rgb_t              w_rdata;
    logic              t_we;
    rgb_t              t_rdata;
    logic              t_re;
    rgb_t              wb_rgb;

    assign range_sum  = RANGE_W'(first_reg) + RANGE_W'(span_reg);
    assign range_last = (range_sum > RANGE_W'(ENTRIES - 1)) ? RANGE_W'(ENTRIES - 1) : range_sum;
    assign ent_in_rng = (RANGE_W'(cmd.ent) >= RANGE_W'(first_reg))
                     && (RANGE_W'(cmd.ent) <= range_last);
    assign bank_in    = !cmd.bank || !skip_reg;

    assign host_ok   = (int'(rq_bank_reg) < BANKS) && (int'(rq_entry_reg) < ENTRIES);
    assign host_addr = rq_bank_reg ? ADDR_W'(ENTRIES) + ADDR_W'(rq_entry_reg)
                                   : ADDR_W'(rq_entry_reg);
    assign sweep_addr = cmd.bank ? ADDR_W'(ENTRIES) + ADDR_W'(cmd.ent) : ADDR_W'(cmd.ent);
    assign fill_lvl   = (mode_reg == MODE_FADE_IN) ? 8'd0 : WHITE_LVL;
    assign start_mode = (rq_mode_reg > MODE_FLASH_OUT) ? MODE_NONE : rq_mode_reg;
    assign fc_inc     = fc_reg + 5'd1;

    assign wb_rgb = pfe_step(mode_reg, w_rdata, t_rdata, wb_elig_reg);

    // RAM port steering
    always_comb
    begin
        w_we    = 1'b0;
        w_waddr = sweep_addr;
        w_wdata = '0;
        t_we    = 1'b0;
        if (wb_vld_reg)
        begin
            w_we    = 1'b1;
            w_waddr = wb_addr_reg;
            w_wdata = wb_rgb;
        end
        case (cmd.op)
            OP_CLEAR:
            begin
                w_we    = 1'b1;
                w_waddr = sweep_addr;
                w_wdata = '0;
                t_we    = 1'b1;
            end
            OP_HOST_WR:
            begin
                w_waddr = host_addr;
                w_wdata = rq_rgb_reg;
                w_we    = host_ok && (rq_type_reg == REQ_WR_WORK);
                t_we    = host_ok && (rq_type_reg == REQ_WR_TGT);
            end
            OP_FILL:
            begin
                w_we    = ent_in_rng;
                w_waddr = sweep_addr;
                w_wdata = '{red: fill_lvl, green: fill_lvl, blue: fill_lvl};
            end
            default:
            begin
            end
        endcase
    end

    assign rd_addr = (cmd.op == OP_HOST_RD) ? host_addr : sweep_addr;
    assign w_re    = (cmd.op == OP_HOST_RD) || (cmd.op == OP_SWEEP);
    assign t_re    = (cmd.op == OP_SWEEP);

    pfe_ram #(
        .WIDTH ($bits(rgb_t)),
        .DEPTH (DEPTH)
    ) u_work_ram (
        .clk   (clk),
        .we    (w_we),
        .waddr (w_waddr),
        .wdata (w_wdata),
        .re    (w_re),
        .raddr (rd_addr),
        .rdata (w_rdata)
    );

    pfe_ram #(
        .WIDTH ($bits(rgb_t)),
        .DEPTH (DEPTH)
    ) u_tgt_ram (
        .clk   (clk),
        .we    (t_we),
        .waddr (w_waddr),
        .wdata (w_wdata),
        .re    (t_re),
        .raddr (rd_addr),
        .rdata (t_rdata)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg     <= 6'd0;
            span_reg      <= 6'd63;
            skip_reg      <= 1'b0;
            mode_reg      <= MODE_NONE;
            fc_reg        <= 5'd0;
            wb_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    CFG_FIRST: first_reg <= cfg_data;
                    CFG_SPAN:  span_reg  <= cfg_data;
                    CFG_SKIP:  skip_reg  <= cfg_data[0];
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.op == OP_START)
            begin
                mode_reg <= start_mode;
                fc_reg   <= 5'd0;
            end
            if (cmd.op == OP_TICK && mode_reg != MODE_NONE)
            begin
                fc_reg <= (fc_inc > 5'(FADE_FRAMES - 1)) ? 5'd0 : fc_inc;
            end
            wb_vld_reg <= (cmd.op == OP_SWEEP);
            if (cmd.op == OP_LOAD)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_CAPTURE)
        begin
            rq_type_reg  <= req_type;
            rq_bank_reg  <= bank;
            rq_entry_reg <= entry;
            rq_rgb_reg   <= '{red: red_in, green: green_in, blue: blue_in};
            rq_mode_reg  <= fade_mode;
        end
        if (cmd.op == OP_TICK)
        begin
            tick_done_reg <= (mode_reg == MODE_NONE) || (fc_inc > 5'(FADE_FRAMES - 1));
        end
        if (cmd.op == OP_SWEEP)
        begin
            wb_addr_reg <= sweep_addr;
            wb_elig_reg <= ent_in_rng && bank_in;
        end
        if (cmd.op == OP_LOAD)
        begin
            out_rgb_reg  <= (rq_type_reg == REQ_RD_WORK && host_ok) ? w_rdata : '0;
            out_done_reg <= (rq_type_reg == REQ_TICK) ? tick_done_reg : 1'b0;
            out_fc_reg   <= fc_reg;
        end
    end

    assign stat.mode_active = (mode_reg != MODE_NONE);
    assign stat.fill_needed = (start_mode == MODE_FADE_IN) || (start_mode == MODE_FLASH_IN);
    assign stat.out_free    = !out_valid_reg || !out_stall;

    assign out_valid   = out_valid_reg;
    assign red_out     = out_rgb_reg.red;
    assign green_out   = out_rgb_reg.green;
    assign blue_out    = out_rgb_reg.blue;
    assign done_res    = out_done_reg;
    assign frames_done = out_fc_reg;

    a_fc_range: assert property (@(posedge clk) disable iff (!rst_n)
        fc_reg < 5'(FADE_FRAMES))
        else $error("frame counter past fade length");

    a_wb_no_clash: assert property (@(posedge clk) disable iff (!rst_n)
        wb_vld_reg |-> (cmd.op != OP_HOST_WR && cmd.op != OP_FILL && cmd.op != OP_CLEAR))
        else $error("write-back clashes with another write");

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_LOAD) |-> (!out_valid_reg || !out_stall))
        else $error("result overwritten before it was taken");

endmodule

>>> rtl/palette_fade_engine.sv
// ============================================================================
// palette_fade_engine: palette store with fade and flash effects
// Working and target palettes, two banks of 64 RGB entries, stepped per frame.
// ============================================================================
// Each request gives exactly one result. After reset the block runs a
// clearing pass over both palette RAMs and holds in_stall high meanwhile;
// configuration writes are taken at any time. Requests are handled one at
// a time by a sequencer: a fade-in/flash-in start first fills the in-range
// entries of bank one, one entry per cycle, and a frame tick of an active
// fade runs a sweep that reads and writes back one palette entry per cycle
// through the single write port of the working RAM. A tick with no fade
// active skips the sweep. The result sits in an output register, and the
// next request is accepted while it waits.
module palette_fade_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [pfe_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [5:0]                    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [2:0]                    req_type,
    input  logic                          bank,
    input  logic [5:0]                    entry,
    input  logic [7:0]                    red_in,
    input  logic [7:0]                    green_in,
    input  logic [7:0]                    blue_in,
    input  logic [2:0]                    fade_mode,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [7:0]                    red_out,
    output logic [7:0]                    green_out,
    output logic [7:0]                    blue_out,
    output logic                          done_res,
    output logic [4:0]                    frames_done
);
    import pfe_pkg::*;

    pfe_cmd_t  cmd;
    pfe_stat_t stat;

    // sequencer: owns the entry counter and decides the op each cycle
    pfe_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .req_type (req_type),
        .stat     (stat),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    // stores, fade state and the result register
    pfe_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req_type    (req_type),
        .bank        (bank),
        .entry       (entry),
        .red_in      (red_in),
        .green_in    (green_in),
        .blue_in     (blue_in),
        .fade_mode   (fade_mode),
        .out_stall   (out_stall),
        .out_valid   (out_valid),
        .red_out     (red_out),
        .green_out   (green_out),
        .blue_out    (blue_out),
        .done_res    (done_res),
        .frames_done (frames_done),
        .stat        (stat)
    );

endmodule
